// File: sv/sawlc_pkg.sv
// Shared types and constants for the set-associative write-back LRU cache.
// Used by the front, queue, back and top-level modules.
package sawlc_pkg;

  localparam int WAYS_MAX = 8;
  localparam int SETS_MAX = 32;
  localparam int BLK_MAX  = 8;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_BLOCK = 2'd0,
    CFG_SETS  = 2'd1,
    CFG_WAYS  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_HIT,
    OP_MISS,
    OP_FILL
  } op_t;

  typedef enum logic [2:0] {
    RK_READ  = 3'd0,
    RK_WRITE = 3'd1,
    RK_WB    = 3'd2,
    RK_EVICT = 3'd3,
    RK_REQ   = 3'd4
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic        wr;
    logic [7:0]  line;       // {way, set}
    logic [2:0]  woff;
    logic [2:0]  aoff;
    logic [31:0] wdata;
    logic [31:0] sdata;
    logic [15:0] addr;
    logic        fill_last;
    logic        vic_valid;
    logic        vic_dirty;
    logic [15:0] vic_base;
    logic [3:0]  bw;
  } cmd_t;

endpackage

// File: sv/sawlc_queue.sv
// Two-entry command FIFO between the front and back of the cache.
// Depends on sawlc_pkg for the command type.
module sawlc_queue import sawlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

// File: sv/sawlc_front.sv
// Front end: config registers, tag/LRU/valid/dirty state, hit/miss classification.
// Pushes commands to the back through sawlc_queue; depends on sawlc_pkg.
module sawlc_front import sawlc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [31:0] data_word,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  typedef logic [WAYS_MAX-1:0][15:0] tag_row_t;
  typedef logic [WAYS_MAX-1:0][2:0]  rank_row_t;

  logic [1:0]  bwl;
  logic [2:0]  scl;
  logic [3:0]  nways;

  logic        s1_valid;
  action_t     s1_act;
  logic [15:0] s1_addr;
  logic [31:0] s1_data;

  logic        pend_valid;
  logic        pend_write;
  logic [15:0] pend_addr;
  logic [31:0] pend_data;
  logic [2:0]  pend_way;
  logic [3:0]  fill_count;

  logic [WAYS_MAX-1:0] valid_bits [SETS_MAX];
  logic [WAYS_MAX-1:0] dirty_bits [SETS_MAX];

  tag_row_t  tag_mem  [SETS_MAX];
  rank_row_t rank_mem [SETS_MAX];
  tag_row_t  tag_row;
  rank_row_t rank_row;

  logic [1:0]  eb;
  logic [2:0]  es;
  logic [3:0]  ew;
  logic [3:0]  bw;
  logic [2:0]  bwm;
  logic        accept;
  logic [4:0]  rd_set;
  logic        is_fill;
  logic [15:0] c_addr;
  logic [4:0]  c_set;
  logic [15:0] c_tag;
  logic [2:0]  c_off;
  logic [WAYS_MAX-1:0] vrow;
  logic [WAYS_MAX-1:0] drow;
  logic [WAYS_MAX-1:0] in_way;
  logic        hit;
  logic [2:0]  hway;
  logic [2:0]  vic;
  logic        vic_found;
  logic [2:0]  hrank;
  logic [2:0]  top_rank;
  rank_row_t   rank_hit;
  rank_row_t   rank_fill;
  tag_row_t    tag_fill;
  logic        fill_last;
  logic [31:0] base32;
  logic        do_hit;
  logic        do_miss;
  logic        do_fill;

  function automatic logic [4:0] set_of(input logic [15:0] a, input logic [1:0] b,
                                        input logic [2:0] s);
    logic [15:0] sh;
    logic [5:0]  mask;
    sh   = a >> b;
    mask = (6'd1 << s) - 6'd1;
    return sh[4:0] & mask[4:0];
  endfunction

  assign eb  = bwl;
  assign es  = (scl > 3'd5) ? 3'd5 : scl;
  assign ew  = (nways == 4'd0) ? 4'd1 : ((nways > 4'd8) ? 4'd8 : nways);
  assign bw  = 4'd1 << eb;
  assign bwm = 3'(bw - 4'd1);

  assign busy   = s1_valid || q_full;
  assign accept = start && !busy;
  assign rd_set = set_of((action_t'(action) == ACT_FILL) ? pend_addr : address, eb, es);

  assign is_fill  = (s1_act == ACT_FILL);
  assign c_addr   = is_fill ? pend_addr : s1_addr;
  assign c_set    = set_of(c_addr, eb, es);
  assign c_tag    = (c_addr >> eb) >> es;
  assign c_off    = c_addr[2:0] & bwm;
  assign vrow     = valid_bits[c_set];
  assign drow     = dirty_bits[c_set];
  assign top_rank = 3'(ew - 4'd1);
  assign fill_last = ((fill_count + 4'd1) == bw);

  always_comb begin
    hit       = 1'b0;
    hway      = 3'd0;
    vic_found = 1'b0;
    vic       = 3'd0;
    for (int j = 0; j < WAYS_MAX; j++) begin
      in_way[j] = (4'(j) < ew);
      if (!hit && in_way[j] && vrow[j] && tag_row[j] == c_tag) begin
        hit  = 1'b1;
        hway = 3'(j);
      end
      if (!vic_found && in_way[j] && (!vrow[j] || rank_row[j] == 3'd0)) begin
        vic_found = 1'b1;
        vic       = 3'(j);
      end
    end
  end

  assign hrank = rank_row[hway];

  always_comb begin
    rank_hit  = rank_row;
    rank_fill = rank_row;
    tag_fill  = tag_row;
    for (int k = 0; k < WAYS_MAX; k++) begin
      if (in_way[k] && vrow[k] && rank_row[k] > hrank) begin
        rank_hit[k] = rank_row[k] - 3'd1;
      end
      if (in_way[k] && 3'(k) != pend_way && vrow[k] && rank_row[k] != 3'd0) begin
        rank_fill[k] = rank_row[k] - 3'd1;
      end
    end
    rank_hit[hway]      = top_rank;
    rank_fill[pend_way] = top_rank;
    tag_fill[pend_way]  = c_tag;
  end

  assign base32 = ((32'(tag_row[vic]) << es) | 32'(c_set)) << eb;

  assign do_hit  = s1_valid && !is_fill && s1_act != ACT_NONE && !pend_valid && hit;
  assign do_miss = s1_valid && !is_fill && s1_act != ACT_NONE && !pend_valid && !hit;
  assign do_fill = s1_valid && is_fill && pend_valid;
  assign push    = do_hit || do_miss || do_fill;

  always_comb begin
    cmd           = '0;
    cmd.op        = do_fill ? OP_FILL : (do_hit ? OP_HIT : OP_MISS);
    cmd.wr        = do_fill ? pend_write : (s1_act == ACT_WRITE);
    cmd.line      = {do_fill ? pend_way : (do_hit ? hway : vic), c_set};
    cmd.woff      = do_fill ? fill_count[2:0] : c_off;
    cmd.aoff      = c_off;
    cmd.wdata     = s1_data;
    cmd.sdata     = pend_data;
    cmd.addr      = do_fill ? pend_addr : (do_hit ? s1_addr : (s1_addr & ~16'(bwm)));
    cmd.fill_last = fill_last;
    cmd.vic_valid = vrow[vic];
    cmd.vic_dirty = drow[vic];
    cmd.vic_base  = base32[15:0];
    cmd.bw        = bw;
  end

  always_ff @(posedge clk) begin
    tag_row  <= tag_mem[rd_set];
    rank_row <= rank_mem[rd_set];
    if (do_hit) begin
      rank_mem[c_set] <= rank_hit;
    end
    if (do_fill && fill_last) begin
      rank_mem[c_set] <= rank_fill;
      tag_mem[c_set]  <= tag_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act  <= action_t'(action);
      s1_addr <= address;
      s1_data <= data_word;
    end
    if (do_miss) begin
      pend_write <= (s1_act == ACT_WRITE);
      pend_addr  <= s1_addr;
      pend_data  <= s1_data;
      pend_way   <= vic;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bwl        <= 2'd0;
      scl        <= 3'd0;
      nways      <= 4'd1;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
      fill_count <= 4'd0;
      for (int i = 0; i < SETS_MAX; i++) begin
        valid_bits[i] <= '0;
        dirty_bits[i] <= '0;
      end
    end else begin
      s1_valid <= accept && action_t'(action) != ACT_NONE;
      if (do_hit && s1_act == ACT_WRITE) begin
        dirty_bits[c_set][hway] <= 1'b1;
      end
      if (do_miss) begin
        pend_valid <= 1'b1;
        fill_count <= 4'd0;
      end
      if (do_fill) begin
        if (fill_last) begin
          pend_valid                  <= 1'b0;
          fill_count                  <= 4'd0;
          valid_bits[c_set][pend_way] <= 1'b1;
          dirty_bits[c_set][pend_way] <= pend_write;
        end else begin
          fill_count <= fill_count + 4'd1;
        end
      end
      if (cfg_write && cfg_idx_t'(cfg_index) != CFG_NONE) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BLOCK: bwl   <= cfg_data[1:0];
          CFG_SETS:  scl   <= cfg_data[2:0];
          CFG_WAYS:  nways <= cfg_data;
          default:   ;
        endcase
        pend_valid <= 1'b0;
        fill_count <= 4'd0;
        for (int i = 0; i < SETS_MAX; i++) begin
          valid_bits[i] <= '0;
          dirty_bits[i] <= '0;
        end
      end
    end
  end

endmodule

// File: sv/sawlc_back.sv
// Back end: data word array and result sequencing for hits, misses and fills.
// Pops commands from sawlc_queue; depends on sawlc_pkg.
module sawlc_back import sawlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  cmd_t               q_head,
  output logic               pop,
  output logic               result_strobe,
  output logic [2:0]         result_kind,
  output logic [15:0]        result_address,
  output logic signed [31:0] result_data,
  output logic [3:0]         range_words,
  output logic               last_of_run
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_RDOUT,
    S_FILLW,
    S_WBRD,
    S_WBOUT,
    S_EVICT,
    S_REQ
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [2:0]  p;

  logic [31:0] dmem [WAYS_MAX*SETS_MAX*BLK_MAX];
  logic [31:0] rdata;
  logic [10:0] mem_addr;
  logic        mem_we;

  assign pop = (state == S_IDLE) && q_nonempty;

  always_comb begin
    mem_addr = {cur.line, cur.woff};
    mem_we   = 1'b0;
    case (state)
      S_ACC:   mem_we = cur.wr;
      S_FILLW: mem_we = 1'b1;
      S_WBRD:  mem_addr = {cur.line, p};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_addr] <= cur.wdata;
    end
    rdata <= dmem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_nonempty) begin
            cur <= q_head;
            p   <= 3'd0;
            case (q_head.op)
              OP_HIT:  state <= S_ACC;
              OP_FILL: state <= S_FILLW;
              default: begin
                if (!q_head.vic_valid) begin
                  state <= S_REQ;
                end else if (q_head.vic_dirty) begin
                  state <= S_WBRD;
                end else begin
                  state <= S_EVICT;
                end
              end
            endcase
          end
        end
        S_ACC: begin
          if (cur.wr) begin
            result_strobe  <= 1'b1;
            result_kind    <= RK_WRITE;
            result_address <= cur.addr;
            result_data    <= '0;
            range_words    <= 4'd1;
            last_of_run    <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_RDOUT;
          end
        end
        S_RDOUT: begin
          result_strobe  <= 1'b1;
          result_kind    <= RK_READ;
          result_address <= cur.addr;
          result_data    <= rdata;
          range_words    <= 4'd1;
          last_of_run    <= 1'b1;
          state          <= S_IDLE;
        end
        S_FILLW: begin
          if (cur.fill_last) begin
            cur.woff  <= cur.aoff;
            cur.wdata <= cur.sdata;
            state     <= S_ACC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_WBRD: state <= S_WBOUT;
        S_WBOUT: begin
          result_strobe  <= 1'b1;
          result_kind    <= RK_WB;
          result_address <= cur.vic_base + 16'(p);
          result_data    <= rdata;
          range_words    <= 4'd1;
          last_of_run    <= 1'b0;
          if (p == 3'(cur.bw - 4'd1)) begin
            state <= S_REQ;
          end else begin
            p     <= p + 3'd1;
            state <= S_WBRD;
          end
        end
        S_EVICT: begin
          result_strobe  <= 1'b1;
          result_kind    <= RK_EVICT;
          result_address <= cur.vic_base;
          result_data    <= '0;
          range_words    <= cur.bw;
          last_of_run    <= 1'b0;
          state          <= S_REQ;
        end
        S_REQ: begin
          result_strobe  <= 1'b1;
          result_kind    <= RK_REQ;
          result_address <= cur.addr;
          result_data    <= '0;
          range_words    <= cur.bw;
          last_of_run    <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/set_assoc_writeback_lru_cache_core.sv
// Top level of the set-associative write-back write-allocate LRU word cache.
// Instantiates sawlc_front, sawlc_queue and sawlc_back; depends on sawlc_pkg.
//
// An item is taken when start is high and busy is low. The front reads one set's
// tag and LRU row and classifies the item on the next cycle, so busy stays high
// while an item is classified and while the two-entry command queue is full. The
// back, sharing one data array port, answers a write hit from S_ACC and a read
// hit from S_RDOUT after a registered array read, reads each write-back word in
// S_WBRD and gives it out in S_WBOUT, and posts eviction notice and fill request
// one a cycle. Results appear for one cycle on result_strobe and cannot be held
// off. Valid and dirty bits reset at once; no clearing pass. Write config only
// while idle; any write to a defined register invalidates the whole cache.
module set_assoc_writeback_lru_cache_core import sawlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [15:0]        address,
  input  logic signed [31:0] data_word,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output logic               result_strobe,
  output logic [2:0]         result_kind,
  output logic [15:0]        result_address,
  output logic signed [31:0] result_data,
  output logic [3:0]         range_words,
  output logic               last_of_run
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_nonempty;
  logic pop;
  cmd_t q_head;

  sawlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .address   (address),
    .data_word (data_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  sawlc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  sawlc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .pop            (pop),
    .result_strobe  (result_strobe),
    .result_kind    (result_kind),
    .result_address (result_address),
    .result_data    (result_data),
    .range_words    (range_words),
    .last_of_run    (last_of_run)
  );

endmodule

// File: tb/set_assoc_writeback_lru_cache_core_test.sv
// Self-checking testbench for set_assoc_writeback_lru_cache_core.
// Predicts every result of the cache from its own model of sets, ways and LRU ranks.
// Depends on sawlc_pkg and the RTL of the cache core.
module set_assoc_writeback_lru_cache_core_test;
  import sawlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [31:0] data;
    logic [3:0]  range;
    logic        last;
  } cache_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic [15:0]        address;
  logic signed [31:0] data_word;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [3:0]         cfg_data;
  logic               result_strobe;
  logic [2:0]         result_kind;
  logic [15:0]        result_address;
  logic signed [31:0] result_data;
  logic [3:0]         range_words;
  logic               last_of_run;

  // cache model
  logic [1:0]  blk_log2;
  logic [2:0]  sets_log2;
  logic [3:0]  ways_reg;
  logic [15:0] tag_mem [256];
  logic        valid_mem [256];
  logic        dirty_mem [256];
  logic [2:0]  rank_mem [256];
  logic [31:0] word_mem [2048];
  logic        miss_open;
  logic        miss_wr;
  logic [15:0] miss_addr;
  logic [31:0] miss_data;
  int          miss_way;
  int          fill_cnt;

  cache_result_t expected_results[$];
  int  errors;
  int  idle_cycles;
  bit  burst_on;
  int  burst_left;
  int  gap_left;
  logic [15:0] hot_addrs[$];

  set_assoc_writeback_lru_cache_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .address(address), .data_word(data_word), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_strobe(result_strobe),
    .result_kind(result_kind), .result_address(result_address),
    .result_data(result_data), .range_words(range_words), .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_sets_log2();
    return (sets_log2 > 5) ? 5 : int'(sets_log2);
  endfunction

  function automatic int eff_ways();
    if (ways_reg == 0) return 1;
    return (ways_reg > 8) ? 8 : int'(ways_reg);
  endfunction

  function automatic int line_index(int set, int way);
    return (set * eff_ways() + way) % 256;
  endfunction

  function automatic void clear_cache();
    for (int i = 0; i < 256; i++) begin
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
      tag_mem[i] = '0;
      rank_mem[i] = '0;
    end
    miss_open = 1'b0;
    fill_cnt = 0;
  endfunction

  function automatic void push_result(logic [2:0] kind, logic [15:0] addr,
                                      logic [31:0] data, logic [3:0] range,
                                      logic last);
    cache_result_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.range = range;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void access_line(int line, int off, logic wr,
                                      logic [15:0] addr, logic [31:0] data);
    int wi;
    wi = line * 8 + (off % 8);
    if (wr) begin
      word_mem[wi] = data;
      dirty_mem[line] = 1'b1;
      push_result(RK_WRITE, addr, '0, 4'd1, 1'b1);
    end else begin
      push_result(RK_READ, addr, word_mem[wi], 4'd1, 1'b1);
    end
  endfunction

  function automatic void predict_cache(logic [1:0] act, logic [15:0] addr,
                                        logic [31:0] data);
    int b, s, w, bw, off, set, tag, line, victim, pset, r;
    logic [15:0] base;
    b = blk_log2;
    s = eff_sets_log2();
    w = eff_ways();
    bw = 1 << b;
    off = addr & (bw - 1);
    set = (addr >> b) & ((1 << s) - 1);
    tag = (addr >> b) >> s;
    if (act == ACT_NONE) return;
    if (act == ACT_FILL) begin
      if (!miss_open) return;
      pset = (miss_addr >> b) & ((1 << s) - 1);
      line = line_index(pset, miss_way);
      word_mem[line * 8 + (fill_cnt % 8)] = data;
      fill_cnt++;
      if (fill_cnt < bw) return;
      for (int j = 0; j < w; j++) begin
        int o;
        o = line_index(pset, j);
        if (j != miss_way && valid_mem[o] && rank_mem[o] > 0) rank_mem[o]--;
      end
      valid_mem[line] = 1'b1;
      dirty_mem[line] = 1'b0;
      tag_mem[line] = (miss_addr >> b) >> s;
      rank_mem[line] = 3'(w - 1);
      access_line(line, miss_addr & (bw - 1), miss_wr, miss_addr, miss_data);
      miss_open = 1'b0;
      fill_cnt = 0;
      return;
    end
    if (miss_open) return;
    for (int j = 0; j < w; j++) begin
      line = line_index(set, j);
      if (valid_mem[line] && tag_mem[line] == tag) begin
        r = rank_mem[line];
        for (int k = 0; k < w; k++) begin
          int o;
          o = line_index(set, k);
          if (valid_mem[o] && rank_mem[o] > r) rank_mem[o]--;
        end
        rank_mem[line] = 3'(w - 1);
        access_line(line, off, act == ACT_WRITE, addr, data);
        return;
      end
    end
    victim = 0;
    for (int j = 0; j < w; j++) begin
      line = line_index(set, j);
      if (!valid_mem[line] || rank_mem[line] == 0) begin
        victim = j;
        break;
      end
    end
    line = line_index(set, victim);
    if (valid_mem[line]) begin
      base = 16'(((tag_mem[line] << s) | set) << b);
      if (dirty_mem[line]) begin
        for (int p = 0; p < bw; p++)
          push_result(RK_WB, base + 16'(p), word_mem[line * 8 + p], 4'd1, 1'b0);
      end else begin
        push_result(RK_EVICT, base, '0, 4'(bw), 1'b0);
      end
    end
    push_result(RK_REQ, addr & ~16'(bw - 1), '0, 4'(bw), 1'b1);
    miss_open = 1'b1;
    miss_wr = (act == ACT_WRITE);
    miss_addr = addr;
    miss_data = data;
    miss_way = victim;
    fill_cnt = 0;
  endfunction

  // result checker
  always @(posedge clk) begin
    cache_result_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_strobe) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind %0d addr %h", result_kind, result_address);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result_kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, result_kind);
            errors++;
          end
          if (result_address !== e.addr) begin
            $error("result_address exp %h got %h", e.addr, result_address);
            errors++;
          end
          if (result_data !== e.data) begin
            $error("result_data exp %h got %h", e.data, result_data);
            errors++;
          end
          if (range_words !== e.range) begin
            $error("range_words exp %0d got %0d", e.range, range_words);
            errors++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, last_of_run);
            errors++;
          end
        end
      end
      if (result_strobe || (start && !busy) || cfg_write) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [15:0] addr, logic [31:0] data);
    if (burst_on) begin
      if (burst_left == 0) begin
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    address <= addr;
    data_word <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_cache(act, addr, data);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_config(cfg_idx_t idx, logic [3:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_BLOCK: blk_log2 = value[1:0];
      CFG_SETS:  sets_log2 = value[2:0];
      CFG_WAYS:  ways_reg = value;
      default: ;
    endcase
    if (idx != CFG_NONE) clear_cache();
  endtask

  task automatic configure(logic [3:0] b, logic [3:0] s, logic [3:0] w);
    write_config(CFG_BLOCK, b);
    write_config(CFG_SETS, s);
    write_config(CFG_WAYS, w);
    hot_addrs.delete();
  endtask

  task automatic send_fills(int n);
    for (int i = 0; i < n; i++) send_item(ACT_FILL, 16'($urandom), $urandom);
  endtask

  // processor access, answered by fills when it misses
  task automatic access_and_fill(logic [1:0] act, logic [15:0] addr, logic [31:0] data);
    send_item(act, addr, data);
    if (miss_open) send_fills(1 << blk_log2);
  endtask

  task automatic test_directed();
    configure(4'd1, 4'd1, 4'd2);
    access_and_fill(ACT_READ, 16'h0000, 32'h0);
    access_and_fill(ACT_WRITE, 16'h0001, 32'hFFFF_FFFF);
    access_and_fill(ACT_READ, 16'h0001, 32'h0);
    access_and_fill(ACT_WRITE, 16'hFFFF, 32'h8000_0000);
    access_and_fill(ACT_WRITE, 16'h0004, 32'h7FFF_FFFF);
    access_and_fill(ACT_READ, 16'h0008, 32'h0);
    access_and_fill(ACT_READ, 16'h000C, 32'h0);
    access_and_fill(ACT_READ, 16'h0004, 32'h0);
    send_item(ACT_READ, 16'h1000, 32'h1);
    send_item(ACT_WRITE, 16'h2000, 32'h2);
    send_item(ACT_NONE, 16'h3000, 32'h3);
    send_fills(2);
    send_item(ACT_FILL, 16'h0, 32'h5);
    send_item(ACT_NONE, 16'hAAAA, 32'h5555_5555);
    write_config(CFG_NONE, 4'hF);
    access_and_fill(ACT_READ, 16'h0000, 32'h0);
  endtask

  task automatic test_random_phase(logic [3:0] b, logic [3:0] s, logic [3:0] w, int n);
    logic [15:0] a;
    int r;
    configure(b, s, w);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (hot_addrs.size() != 0 && r < 50)
        a = hot_addrs[$urandom_range(0, hot_addrs.size() - 1)] ^ 16'($urandom_range(0, 7));
      else if (r < 85)
        a = 16'($urandom_range(0, 255));
      else
        a = 16'($urandom);
      if (hot_addrs.size() < 12) hot_addrs.push_back(a);
      r = $urandom_range(0, 99);
      if (r < 45) access_and_fill(ACT_READ, a, $urandom);
      else if (r < 90) access_and_fill(ACT_WRITE, a, $urandom);
      else if (r < 95) send_item(ACT_FILL, a, $urandom);
      else send_item(ACT_NONE, a, $urandom);
    end
    if (miss_open) send_fills(1 << blk_log2);
  endtask

  task automatic test_random();
    burst_on = 1'b1;
    test_random_phase(4'd0, 4'd0, 4'd1, 10);
    test_random_phase(4'd3, 4'd5, 4'd8, 15);
    test_random_phase(4'd2, 4'd2, 4'd4, 18);
    test_random_phase(4'd1, 4'd7, 4'd0, 12);
    test_random_phase(4'd3, 4'd1, 4'd15, 14);
    test_random_phase(4'd0, 4'd3, 4'd3, 15);
    test_random_phase(4'd2, 4'd6, 4'd8, 15);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_READ;
    address = '0;
    data_word = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_BLOCK;
    cfg_data = '0;
    errors = 0;
    burst_on = 1'b0;
    burst_left = 0;
    gap_left = 0;
    blk_log2 = 0;
    sets_log2 = 0;
    ways_reg = 1;
    clear_cache();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random();
    drain_results();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
